// ===== sv/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants of the 3x3 Gram-Schmidt core
// Holds beat structs, vector types, internal widths and stage latencies.
// ----------------------------------------------------------------------------
package gsr_pkg;

    localparam int IN_WIDTH     = 16;
    localparam int OUT_WIDTH    = 16;
    localparam int OUT_FRAC_DEF = 14;

    // Working fraction of the scaled vectors and unit vectors (Q1.30)
    localparam int WFRAC = 30;
    // Raw component before block scaling, signed
    localparam int VW    = 35;
    // Magnitude of a raw component
    localparam int MW    = VW - 1;
    // Bit position of the leading one of a raw magnitude
    localparam int PW    = $clog2(MW);
    // Scaled or unit component, signed
    localparam int SW    = 32;
    // Magnitude of a scaled or unit component
    localparam int UW    = WFRAC + 1;
    // Squared norm
    localparam int N2W   = 2 * UW;
    // Dividend of the normalizing divide
    localparam int NUMW  = UW + WFRAC;

    localparam int BS_LAT   = 2;
    localparam int UNIT_LAT = 2 * UW + 4;
    localparam int PROJ_LAT = 5;

    typedef logic [2:0][VW-1:0] rvec_t;
    typedef logic [2:0][SW-1:0] svec_t;

    typedef struct packed {
        logic vld;
        logic ok;
    } ctl_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] c0_x;
        logic signed [IN_WIDTH-1:0] c0_y;
        logic signed [IN_WIDTH-1:0] c0_z;
        logic signed [IN_WIDTH-1:0] c1_x;
        logic signed [IN_WIDTH-1:0] c1_y;
        logic signed [IN_WIDTH-1:0] c1_z;
        logic signed [IN_WIDTH-1:0] c2_x;
        logic signed [IN_WIDTH-1:0] c2_y;
        logic signed [IN_WIDTH-1:0] c2_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] e0_x;
        logic signed [OUT_WIDTH-1:0] e0_y;
        logic signed [OUT_WIDTH-1:0] e0_z;
        logic signed [OUT_WIDTH-1:0] e1_x;
        logic signed [OUT_WIDTH-1:0] e1_y;
        logic signed [OUT_WIDTH-1:0] e1_z;
        logic signed [OUT_WIDTH-1:0] e2_x;
        logic signed [OUT_WIDTH-1:0] e2_y;
        logic signed [OUT_WIDTH-1:0] e2_z;
        logic                        degenerate;
    } out_beat_t;

endpackage

// ===== sv/gsr_delay.sv =====
// ----------------------------------------------------------------------------
// gsr_delay: stallable delay line
// Carries side data alongside a pipelined unit, advancing on enable.
// ----------------------------------------------------------------------------
module gsr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== sv/gsr_block_scale.sv =====
// ----------------------------------------------------------------------------
// gsr_block_scale: power-of-two block scaling of a 3-vector
// Brings the largest magnitude into [2^29, 2^30], rounding on right shifts.
// ----------------------------------------------------------------------------
module gsr_block_scale (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gsr_pkg::ctl_t  ctl_in,
    input  gsr_pkg::rvec_t v_in,
    output gsr_pkg::ctl_t  ctl_out,
    output gsr_pkg::svec_t v_out
);
    import gsr_pkg::*;

    ctl_t               ctl1_reg;
    ctl_t               ctl2_reg;
    logic [2:0][MW-1:0] mag_reg;
    logic [2:0][MW-1:0] mag_next;
    logic [2:0]         neg_reg;
    logic [2:0]         neg_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic [MW-1:0]      any_bits;
    logic               nz_next;
    svec_t              v_reg;
    svec_t              v_next;

    // Stage 1: magnitudes and leading-one position of their union
    always_comb begin
        any_bits = '0;
        for (int i = 0; i < 3; i++) begin
            neg_next[i] = v_in[i][VW-1];
            mag_next[i] = neg_next[i] ? MW'(-v_in[i]) : v_in[i][MW-1:0];
            any_bits    = any_bits | mag_next[i];
        end
        pos_next = '0;
        for (int b = 0; b < MW; b++) begin
            if (any_bits[b]) begin
                pos_next = PW'(b);
            end
        end
        nz_next = |any_bits;
    end

    // Stage 2: shift left exactly, or right with round half away from zero
    always_comb begin
        logic [MW-1:0] up;
        logic [MW:0]   dn;
        logic [MW:0]   rnd;
        logic [UW-1:0] m_sc;
        up   = '0;
        dn   = '0;
        rnd  = '0;
        m_sc = '0;
        for (int i = 0; i < 3; i++) begin
            if (pos_reg <= PW'(WFRAC - 1)) begin
                up   = mag_reg[i] << (PW'(WFRAC - 1) - pos_reg);
                m_sc = UW'(up);
            end else begin
                dn   = {mag_reg[i], 1'b0} >> (pos_reg - PW'(WFRAC - 1));
                rnd  = (dn >> 1) + (MW + 1)'(dn[0]);
                m_sc = UW'(rnd);
            end
            v_next[i] = neg_reg[i] ? SW'(-{1'b0, m_sc}) : SW'({1'b0, m_sc});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= '{vld: ctl_in.vld, ok: ctl_in.ok & nz_next};
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            pos_reg <= pos_next;
            v_reg   <= v_next;
        end
    end

    assign ctl_out = ctl2_reg;
    assign v_out   = v_reg;

endmodule

// ===== sv/gsr_unit.sv =====
// ----------------------------------------------------------------------------
// gsr_unit: pipelined vector normalizer
// Squares, sums, bit-serial square root and three restoring dividers.
// ----------------------------------------------------------------------------
module gsr_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gsr_pkg::ctl_t  ctl_in,
    input  gsr_pkg::svec_t a_in,
    output gsr_pkg::ctl_t  ctl_out,
    output gsr_pkg::svec_t e_out
);
    import gsr_pkg::*;

    localparam int DW = NUMW + 1;

    // Squares stage
    ctl_t                sq_ctl_reg;
    logic [2:0][UW-1:0]  sq_mag_reg;
    logic [2:0][UW-1:0]  sq_mag_next;
    logic [2:0]          sq_neg_reg;
    logic [2:0]          sq_neg_next;
    logic [2:0][N2W-1:0] sq_sqr_reg;
    logic [2:0][N2W-1:0] sq_sqr_next;

    // Square root stages; index 0 holds the squared norm
    logic [N2W-1:0]      rt_rem_reg  [UW+1];
    logic [UW-1:0]       rt_root_reg [UW+1];
    logic [2:0][UW-1:0]  rt_mag_reg  [UW+1];
    logic [2:0]          rt_neg_reg  [UW+1];
    ctl_t                rt_ctl_reg  [UW+1];

    // Divider stages; index 0 holds the rounded dividends
    logic [2:0][DW-1:0]  dv_rem_reg  [UW+1];
    logic [UW-1:0]       dv_den_reg  [UW+1];
    logic [2:0][UW-1:0]  dv_q_reg    [UW+1];
    logic [2:0]          dv_neg_reg  [UW+1];
    ctl_t                dv_ctl_reg  [UW+1];

    ctl_t                fin_ctl_reg;
    svec_t               e_reg;
    svec_t               e_next;
    logic [2:0][DW-1:0]  num_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_neg_next[i] = a_in[i][SW-1];
            sq_mag_next[i] = sq_neg_next[i] ? UW'(-a_in[i]) : a_in[i][UW-1:0];
            sq_sqr_next[i] = N2W'(sq_mag_next[i]) * N2W'(sq_mag_next[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = (DW'(rt_mag_reg[UW][i]) << WFRAC) + DW'(rt_root_reg[UW] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_ctl_reg    <= '0;
            rt_ctl_reg[0] <= '0;
            dv_ctl_reg[0] <= '0;
        end else if (en) begin
            sq_ctl_reg    <= ctl_in;
            rt_ctl_reg[0] <= sq_ctl_reg;
            dv_ctl_reg[0] <= rt_ctl_reg[UW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_mag_reg     <= sq_mag_next;
            sq_neg_reg     <= sq_neg_next;
            sq_sqr_reg     <= sq_sqr_next;
            rt_rem_reg[0]  <= sq_sqr_reg[0] + sq_sqr_reg[1] + sq_sqr_reg[2];
            rt_root_reg[0] <= '0;
            rt_mag_reg[0]  <= sq_mag_reg;
            rt_neg_reg[0]  <= sq_neg_reg;
            dv_rem_reg[0]  <= num_next;
            dv_den_reg[0]  <= rt_root_reg[UW];
            dv_q_reg[0]    <= '0;
            dv_neg_reg[0]  <= rt_neg_reg[UW];
        end
    end

    // One root bit per stage, most significant first
    for (genvar j = 0; j < UW; j++) begin : g_root
        localparam int K = UW - 1 - j;
        logic [N2W+1:0] trial;
        logic           take;
        assign trial = ({(N2W + 2 - UW)'(0), rt_root_reg[j]} << (K + 1))
                     + ((N2W + 2)'(1) << (2 * K));
        assign take  = {2'b00, rt_rem_reg[j]} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_ctl_reg[j+1] <= '0;
            end else if (en) begin
                rt_ctl_reg[j+1] <= rt_ctl_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_rem_reg[j+1]  <= take ? rt_rem_reg[j] - N2W'(trial) : rt_rem_reg[j];
                rt_root_reg[j+1] <= take ? rt_root_reg[j] | (UW'(1) << K) : rt_root_reg[j];
                rt_mag_reg[j+1]  <= rt_mag_reg[j];
                rt_neg_reg[j+1]  <= rt_neg_reg[j];
            end
        end
    end

    // One quotient bit per stage in each of the three lanes
    for (genvar j = 0; j < UW; j++) begin : g_div
        localparam int K = UW - 1 - j;
        logic [DW-1:0]      sub;
        logic [2:0][DW-1:0] rem_next;
        logic [2:0][UW-1:0] q_next;
        assign sub = DW'(dv_den_reg[j]) << K;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (dv_rem_reg[j][i] >= sub) begin
                    rem_next[i] = dv_rem_reg[j][i] - sub;
                    q_next[i]   = dv_q_reg[j][i] | (UW'(1) << K);
                end else begin
                    rem_next[i] = dv_rem_reg[j][i];
                    q_next[i]   = dv_q_reg[j][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_ctl_reg[j+1] <= '0;
            end else if (en) begin
                dv_ctl_reg[j+1] <= dv_ctl_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= q_next;
                dv_den_reg[j+1] <= dv_den_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
            end
        end
    end

    // Clamp to one and restore the sign
    always_comb begin
        logic [UW-1:0] q;
        q = '0;
        for (int i = 0; i < 3; i++) begin
            q = dv_q_reg[UW][i];
            if (q > (UW'(1) << WFRAC)) begin
                q = UW'(1) << WFRAC;
            end
            e_next[i] = dv_neg_reg[UW][i] ? SW'(-{1'b0, q}) : SW'({1'b0, q});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_ctl_reg <= '0;
        end else if (en) begin
            fin_ctl_reg <= dv_ctl_reg[UW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= e_next;
        end
    end

    assign ctl_out = fin_ctl_reg;
    assign e_out   = e_reg;

endmodule

// ===== sv/gsr_proj.sv =====
// ----------------------------------------------------------------------------
// gsr_proj: pipelined projection removal
// Computes base - round(round(e.a / 2^30) * e / 2^30) per component.
// ----------------------------------------------------------------------------
module gsr_proj (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  gsr_pkg::ctl_t  ctl_in,
    input  gsr_pkg::svec_t e_in,
    input  gsr_pkg::svec_t a_in,
    input  gsr_pkg::rvec_t base_in,
    output gsr_pkg::ctl_t  ctl_out,
    output gsr_pkg::rvec_t u_out
);
    import gsr_pkg::*;

    localparam int PRW = 2 * SW;
    localparam int PPW = SW + 2;
    localparam int PEW = PPW + SW;

    ctl_t                  ctl_reg [PROJ_LAT];
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [PRW-1:0] dot_reg;
    logic signed [PPW-1:0] p_reg;
    logic signed [PEW-1:0] pe_reg [3];
    svec_t                 e1_reg;
    svec_t                 e2_reg;
    svec_t                 e3_reg;
    rvec_t                 b1_reg;
    rvec_t                 b2_reg;
    rvec_t                 b3_reg;
    rvec_t                 b4_reg;
    rvec_t                 u_reg;

    function automatic logic signed [PEW-1:0] rnd_wf(input logic signed [PEW-1:0] x);
        logic [PEW-1:0] m;
        m = x[PEW-1] ? PEW'(-x) : PEW'(x);
        m = (m + (PEW'(1) << (WFRAC - 1))) >> WFRAC;
        return x[PEW-1] ? -$signed(m) : $signed(m);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < PROJ_LAT; s++) begin
                ctl_reg[s] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s < PROJ_LAT; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= $signed(e_in[i]) * $signed(a_in[i]);
            end
            e1_reg  <= e_in;
            b1_reg  <= base_in;

            dot_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            e2_reg  <= e1_reg;
            b2_reg  <= b1_reg;

            p_reg   <= PPW'(rnd_wf(PEW'(dot_reg)));
            e3_reg  <= e2_reg;
            b3_reg  <= b2_reg;

            for (int i = 0; i < 3; i++) begin
                pe_reg[i] <= p_reg * $signed(e3_reg[i]);
            end
            b4_reg  <= b3_reg;

            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= VW'($signed(b4_reg[i]) - $signed(VW'(rnd_wf(pe_reg[i]))));
            end
        end
    end

    assign ctl_out = ctl_reg[PROJ_LAT-1];
    assign u_out   = u_reg;

endmodule

// ===== sv/gram_schmidt_3x3_orthonormalizer_core.sv =====
// ----------------------------------------------------------------------------
// gram_schmidt_3x3_orthonormalizer_core: classical Gram-Schmidt on a 3x3 matrix
// Throughput: one matrix per cycle; the whole pipeline holds only while a
// finished beat waits at the output register.
// The depth is set by the three normalizers, each a one-bit-per-stage square
// root followed by one-bit-per-stage dividers.
// Reset: synchronous active-low aresetn clears every stage valid bit.
// ----------------------------------------------------------------------------
module gram_schmidt_3x3_orthonormalizer_core #(
    parameter int OUT_FRAC = gsr_pkg::OUT_FRAC_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gsr_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gsr_pkg::out_beat_t m_data
);
    import gsr_pkg::*;

    // Shift from Q1.30 down to the output fraction, and its rounding half
    localparam int            SH   = WFRAC - OUT_FRAC;
    localparam logic [SW-1:0] HALF = (SW'(1) << SH) >> 1;
    localparam logic [SW-1:0] LIM  = SW'(1) << OUT_FRAC;

    // Global advance: every stage moves unless a result is held at the port
    logic      en;
    logic      m_valid_reg;
    out_beat_t m_data_reg;
    out_beat_t m_data_next;

    ctl_t  ctl_in;
    rvec_t raw0, raw1, raw2;
    ctl_t  ctl_b0, ctl_b1, ctl_b2, ctl_v;
    svec_t v0s, v1s, v2s;

    ctl_t  ctl_e0;
    svec_t e0, v1s_d, v2s_d;

    rvec_t base1, base2;
    ctl_t  ctl_pa, ctl_pb, ctl_u1;
    rvec_t u1, w;
    svec_t e0_p, v2s_p;

    ctl_t  ctl_u1s;
    svec_t u1s;
    ctl_t  ctl_e1;
    svec_t e1, e0_q, v2s_q;
    rvec_t w_q;

    ctl_t  ctl_u2, ctl_u2s, ctl_e2;
    rvec_t u2;
    svec_t u2s, e2, e0_f, e1_f;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign ctl_in  = '{vld: s_valid, ok: 1'b1};

    // Sign-extend the input columns into the raw vector width
    assign raw0 = {VW'(s_data.c0_z), VW'(s_data.c0_y), VW'(s_data.c0_x)};
    assign raw1 = {VW'(s_data.c1_z), VW'(s_data.c1_y), VW'(s_data.c1_x)};
    assign raw2 = {VW'(s_data.c2_z), VW'(s_data.c2_y), VW'(s_data.c2_x)};

    // Block-scale all three columns side by side; any zero column degenerates
    gsr_block_scale u_bs0 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_in), .v_in(raw0), .ctl_out(ctl_b0), .v_out(v0s)
    );
    gsr_block_scale u_bs1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_in), .v_in(raw1), .ctl_out(ctl_b1), .v_out(v1s)
    );
    gsr_block_scale u_bs2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_in), .v_in(raw2), .ctl_out(ctl_b2), .v_out(v2s)
    );
    assign ctl_v = '{vld: ctl_b0.vld, ok: ctl_b0.ok & ctl_b1.ok & ctl_b2.ok};

    // e0 from the first column; hold the other two columns alongside
    gsr_unit u_unit0 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_v), .a_in(v0s), .ctl_out(ctl_e0), .e_out(e0)
    );
    gsr_delay #(.WIDTH(2 * $bits(svec_t)), .DEPTH(UNIT_LAT)) u_dly1 (
        .aclk(aclk), .en(en), .d({v1s, v2s}), .q({v1s_d, v2s_d})
    );

    // Strip the e0 component from both remaining columns at once
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            base1[i] = VW'($signed(v1s_d[i]));
            base2[i] = VW'($signed(v2s_d[i]));
        end
    end

    gsr_proj u_proj0a (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_e0), .e_in(e0), .a_in(v1s_d), .base_in(base1),
        .ctl_out(ctl_pa), .u_out(u1)
    );
    gsr_proj u_proj0b (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_e0), .e_in(e0), .a_in(v2s_d), .base_in(base2),
        .ctl_out(ctl_pb), .u_out(w)
    );
    assign ctl_u1 = '{vld: ctl_pa.vld, ok: ctl_pa.ok & ctl_pb.ok};

    gsr_delay #(.WIDTH(2 * $bits(svec_t)), .DEPTH(PROJ_LAT)) u_dly2 (
        .aclk(aclk), .en(en), .d({e0, v2s_d}), .q({e0_p, v2s_p})
    );

    // Rescale and normalize the first residual into e1
    gsr_block_scale u_bs_u1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_u1), .v_in(u1), .ctl_out(ctl_u1s), .v_out(u1s)
    );
    gsr_unit u_unit1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_u1s), .a_in(u1s), .ctl_out(ctl_e1), .e_out(e1)
    );
    gsr_delay #(
        .WIDTH(2 * $bits(svec_t) + $bits(rvec_t)),
        .DEPTH(BS_LAT + UNIT_LAT)
    ) u_dly3 (
        .aclk(aclk), .en(en), .d({e0_p, v2s_p, w}), .q({e0_q, v2s_q, w_q})
    );

    // Second projection of the third column, again taken from v2 itself
    gsr_proj u_proj1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_e1), .e_in(e1), .a_in(v2s_q), .base_in(w_q),
        .ctl_out(ctl_u2), .u_out(u2)
    );

    gsr_block_scale u_bs_u2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_u2), .v_in(u2), .ctl_out(ctl_u2s), .v_out(u2s)
    );
    gsr_unit u_unit2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_in(ctl_u2s), .a_in(u2s), .ctl_out(ctl_e2), .e_out(e2)
    );
    gsr_delay #(
        .WIDTH(2 * $bits(svec_t)),
        .DEPTH(PROJ_LAT + BS_LAT + UNIT_LAT)
    ) u_dly4 (
        .aclk(aclk), .en(en), .d({e0_q, e1}), .q({e0_f, e1_f})
    );

    // Round Q1.30 half away from zero to the output fraction and clamp
    function automatic logic [OUT_WIDTH-1:0] out_fld(input logic [SW-1:0] x);
        logic [SW-1:0] m;
        logic [SW-1:0] o;
        m = x[SW-1] ? SW'(-x) : x;
        m = (m + HALF) >> SH;
        if (m > LIM) begin
            m = LIM;
        end
        o = x[SW-1] ? SW'(-m) : m;
        return o[OUT_WIDTH-1:0];
    endfunction

    always_comb begin
        m_data_next = '0;
        if (ctl_e2.ok) begin
            m_data_next.e0_x = out_fld(e0_f[0]);
            m_data_next.e0_y = out_fld(e0_f[1]);
            m_data_next.e0_z = out_fld(e0_f[2]);
            m_data_next.e1_x = out_fld(e1_f[0]);
            m_data_next.e1_y = out_fld(e1_f[1]);
            m_data_next.e1_z = out_fld(e1_f[2]);
            m_data_next.e2_x = out_fld(e2[0]);
            m_data_next.e2_y = out_fld(e2[1]);
            m_data_next.e2_z = out_fld(e2[2]);
        end else begin
            // Drop the unit vectors and flag the zero-length case
            m_data_next.degenerate = 1'b1;
        end
    end

    // Output register: load on advance, hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl_e2.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/gsr_checker.sv =====
// ----------------------------------------------------------------------------
// gsr_checker: port-level checks of the Gram-Schmidt core
// Watches the handshakes and the degenerate result form.
// ----------------------------------------------------------------------------
module gsr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input gsr_pkg::out_beat_t m_data
);
    import gsr_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.e0_x == 0 && m_data.e0_y == 0 && m_data.e0_z == 0 &&
            m_data.e1_x == 0 && m_data.e1_y == 0 && m_data.e1_z == 0 &&
            m_data.e2_x == 0 && m_data.e2_y == 0 && m_data.e2_z == 0)
        else $error("degenerate beat carries nonzero unit fields");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind gram_schmidt_3x3_orthonormalizer_core gsr_checker u_gsr_checker (.*);

// ===== test/tb_gram_schmidt_3x3_orthonormalizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_gram_schmidt_3x3_orthonormalizer_core: self-checking bench of the core
// Streams 3x3 matrices through the core, predicts each untyped basis in
// fixed point and compares every output beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_gram_schmidt_3x3_orthonormalizer_core;

    import gsr_pkg::*;

    localparam int     N_RANDOM   = 1080;
    localparam int     CYCLE_CAP  = 400000;
    localparam int     DRAIN_WAIT = 300;
    localparam int     ZERO_VEC   = 99;
    localparam longint WONE       = 64'sd1 << WFRAC;
    localparam longint WLOW       = 64'sd1 << (WFRAC - 1);
    localparam longint OLIM       = 64'sd1 << OUT_FRAC_DEF;

    typedef struct {
        in_beat_t  mat;
        bit        typed;
        out_beat_t basis;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    out_beat_t basis_q[$];
    bit        typed_q[$];
    out_beat_t typed_val_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  hold_cnt      = 0;
    int  n_bad         = 0;
    int  n_beats_out   = 0;
    int  n_degen       = 0;
    int  cycle_cnt     = 0;

    gram_schmidt_3x3_orthonormalizer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point basis predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned mag(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // Shift right, rounding half away from zero
    function automatic longint rnd_shr(longint x, int s);
        longint unsigned m;
        m = mag(x);
        if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Bring the largest magnitude into [2^29, 2^30]; flag an all-zero vector
    task automatic block_scale(inout longint a0, inout longint a1, inout longint a2,
                               output bit nz);
        longint unsigned m;
        int s;
        m = mag(a0);
        if (mag(a1) > m) m = mag(a1);
        if (mag(a2) > m) m = mag(a2);
        nz = (m != 0);
        s  = 0;
        if (!nz) begin
        end else if (m < WLOW) begin
            while ((m << s) < WLOW) s++;
            a0 = a0 * (64'sd1 << s);
            a1 = a1 * (64'sd1 << s);
            a2 = a2 * (64'sd1 << s);
        end else begin
            while ((m >> s) >= WONE) s++;
            a0 = rnd_shr(a0, s);
            a1 = rnd_shr(a1, s);
            a2 = rnd_shr(a2, s);
        end
    endtask

    task automatic make_unit(input longint a0, input longint a1, input longint a2,
                             output longint e0, output longint e1, output longint e2);
        longint unsigned len;
        longint unsigned q[3];
        longint a[3];
        a[0] = a0; a[1] = a1; a[2] = a2;
        len = isqrt(mag(a0) * mag(a0) + mag(a1) * mag(a1) + mag(a2) * mag(a2));
        for (int i = 0; i < 3; i++) begin
            q[i] = ((mag(a[i]) << WFRAC) + len / 2) / len;
            if (q[i] > WONE) q[i] = WONE;
        end
        e0 = a0 < 0 ? -longint'(q[0]) : longint'(q[0]);
        e1 = a1 < 0 ? -longint'(q[1]) : longint'(q[1]);
        e2 = a2 < 0 ? -longint'(q[2]) : longint'(q[2]);
    endtask

    function automatic logic [15:0] to_out(longint e);
        longint o;
        o = rnd_shr(e, WFRAC - OUT_FRAC_DEF);
        if (o > OLIM) o = OLIM;
        if (o < -OLIM) o = -OLIM;
        return o[15:0];
    endfunction

    task automatic predict_basis(input in_beat_t b, output out_beat_t r);
        longint v[9];
        longint e[9];
        longint u[3];
        longint p;
        bit ok, nz;
        v[0] = b.c0_x; v[1] = b.c0_y; v[2] = b.c0_z;
        v[3] = b.c1_x; v[4] = b.c1_y; v[5] = b.c1_z;
        v[6] = b.c2_x; v[7] = b.c2_y; v[8] = b.c2_z;
        ok = 1'b1;
        for (int c = 0; c < 3; c++) begin
            block_scale(v[3*c], v[3*c+1], v[3*c+2], nz);
            ok = ok & nz;
        end
        if (ok) begin
            make_unit(v[0], v[1], v[2], e[0], e[1], e[2]);
            p = rnd_shr(e[0]*v[3] + e[1]*v[4] + e[2]*v[5], WFRAC);
            for (int i = 0; i < 3; i++) u[i] = v[3+i] - rnd_shr(p * e[i], WFRAC);
            block_scale(u[0], u[1], u[2], ok);
        end
        if (ok) begin
            make_unit(u[0], u[1], u[2], e[3], e[4], e[5]);
            for (int i = 0; i < 3; i++) u[i] = v[6+i];
            // classical scheme: both coefficients come from the scaled third column
            for (int k = 0; k < 2; k++) begin
                p = rnd_shr(e[3*k]*v[6] + e[3*k+1]*v[7] + e[3*k+2]*v[8], WFRAC);
                for (int i = 0; i < 3; i++) u[i] = u[i] - rnd_shr(p * e[3*k+i], WFRAC);
            end
            block_scale(u[0], u[1], u[2], ok);
        end
        if (ok) make_unit(u[0], u[1], u[2], e[6], e[7], e[8]);
        r = '0;
        if (ok) begin
            r.e0_x = to_out(e[0]); r.e0_y = to_out(e[1]); r.e0_z = to_out(e[2]);
            r.e1_x = to_out(e[3]); r.e1_y = to_out(e[4]); r.e1_z = to_out(e[5]);
            r.e2_x = to_out(e[6]); r.e2_y = to_out(e[7]); r.e2_z = to_out(e[8]);
        end
        r.degenerate = !ok;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: queue a basis per input beat, check each output beat
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_beat_t want;
        bit        tf;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Timeout after %0d cycles, %0d bases pending", cycle_cnt, basis_q.size());
            $display("Some tests failed");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            tf = typed_q.pop_front();
            want = typed_val_q.pop_front();
            if (!tf) predict_basis(s_data, want);
            basis_q = {basis_q, want};
        end
        if (aresetn && m_valid && m_ready) begin
            n_beats_out++;
            if (m_data.degenerate) n_degen++;
            if (basis_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("Unexpected output beat %h", m_data);
            end else begin
                want = basis_q.pop_front();
                for (int f = 0; f < 10; f++) begin
                    logic [15:0] ev, av;
                    ev = (f < 9) ? want[144-16*f -: 16] : {15'd0, want.degenerate};
                    av = (f < 9) ? m_data[144-16*f -: 16] : {15'd0, m_data.degenerate};
                    if (ev !== av) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("Beat %0d field %0d: expected %h, got %h",
                                     n_beats_out - 1, f, ev, av);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= 700;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_beat(input in_beat_t b, input bit tf, input out_beat_t tv);
        int gap;
        typed_q     = {typed_q, tf};
        typed_val_q = {typed_val_q, tv};
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        // idle cycles drawn one at a time, so the idle share matches the percentage
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic in_beat_t diag3(logic signed [15:0] d);
        in_beat_t b;
        b = '0;
        b.c0_x = d; b.c1_y = d; b.c2_z = d;
        return b;
    endfunction

    function automatic out_beat_t unit_basis(logic signed [15:0] one);
        out_beat_t r;
        r = '0;
        r.e0_x = one; r.e1_y = one; r.e2_z = one;
        return r;
    endfunction

    function automatic in_beat_t rand_mat(int kind);
        in_beat_t b;
        logic signed [15:0] k;
        logic [159:0] rbits;
        rbits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        b = rbits[143:0];
        case (kind)
            0: begin
                // small entries: deep left shift in block scaling
                b.c0_x = $signed(4'($urandom)); b.c0_y = $signed(4'($urandom));
                b.c0_z = $signed(4'($urandom)); b.c1_x = $signed(4'($urandom));
                b.c1_y = $signed(4'($urandom)); b.c1_z = $signed(4'($urandom));
                b.c2_x = $signed(4'($urandom)); b.c2_y = $signed(4'($urandom));
                b.c2_z = $signed(4'($urandom));
            end
            1: begin
                // second column a multiple of the first
                k = $signed(3'($urandom));
                b.c0_x = $signed(12'($urandom)); b.c0_y = $signed(12'($urandom));
                b.c0_z = $signed(12'($urandom));
                b.c1_x = b.c0_x * k; b.c1_y = b.c0_y * k; b.c1_z = b.c0_z * k;
            end
            2: begin
                // third column inside the span of the first two
                b.c2_x = b.c0_x - b.c1_x; b.c2_y = b.c0_y - b.c1_y;
                b.c2_z = b.c0_z - b.c1_z;
            end
            3: begin
                // sparse: zero the second column now and then, else three scattered entries
                if ($urandom_range(3) == 0) {b.c1_x, b.c1_y, b.c1_z} = '0;
                else {b.c0_y, b.c1_x, b.c2_x} = '0;
            end
            default: begin
            end
        endcase
        return b;
    endfunction

    initial begin
        dir_row_t  rows[$];
        dir_row_t  row;
        in_beat_t  b;
        out_beat_t none;
        none = '0;

        // Directed rows: typed expectation only where it is obvious
        row.typed = 1; row.mat = '0; row.basis = '0; row.basis.degenerate = 1;
        rows = {rows, row};
        row.mat = diag3(16'sd8192);  row.basis = unit_basis(16'sd16384);  rows = {rows, row};
        row.mat = diag3(-16'sd8192); row.basis = unit_basis(-16'sd16384); rows = {rows, row};
        row.mat = diag3(16'sd32767); row.basis = unit_basis(16'sd16384);  rows = {rows, row};
        row.mat = diag3(-16'sd32768); row.basis = unit_basis(-16'sd16384); rows = {rows, row};
        row.mat = diag3(16'sd1);     row.basis = unit_basis(16'sd16384);  rows = {rows, row};
        row.mat = diag3(16'sd1); row.mat.c2_z = 0; row.basis = '0; row.basis.degenerate = 1;
        rows = {rows, row};
        row.mat = diag3(16'sd1); row.mat.c0_x = 0; rows = {rows, row};
        row.mat = diag3(16'sd1); row.mat.c1_y = 0; rows = {rows, row};
        row.typed = 0;
        row.mat = {9{16'sh7fff}}; rows = {rows, row};
        row.mat = {9{16'sh8000}}; rows = {rows, row};
        row.mat = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                   16'sh7fff, 16'sh7fff, 16'sh8000}; rows = {rows, row};
        // second column parallel to the first: zero residual
        row.mat = {16'sd100, 16'sd200, -16'sd300, 16'sd200, 16'sd400, -16'sd600,
                   16'sd0, 16'sd0, 16'sd5}; rows = {rows, row};
        // third column in the plane of the first two
        row.mat = {16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                   16'sd3, 16'sd7, 16'sd0}; rows = {rows, row};
        row.mat = {16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6,
                   16'sd7, 16'sd8, 16'sd10}; rows = {rows, row};
        row.mat = {-16'sd1, 16'sd32767, 16'sd5, 16'sd32767, -16'sd32768, 16'sd1,
                   16'sd12345, -16'sd2222, 16'sd31}; rows = {rows, row};
        row.mat = {16'sd8192, 16'sd8192, 16'sd0, 16'sd8192, 16'sd0, 16'sd8192,
                   16'sd0, 16'sd8192, 16'sd8192}; rows = {rows, row};
        row.mat = {16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd2,
                   16'sd1, 16'sd2, 16'sd3}; rows = {rows, row};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase A: sender idles a quarter of the time, receiver half
        send_idle_pct = 25;
        recv_idle_pct = 50;
        foreach (rows[i]) send_beat(rows[i].mat, rows[i].typed, rows[i].basis);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                // pause until the pipeline drains, then swap who idles
                s_valid <= 1'b0;
                while (basis_q.size() != 0 || typed_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
                send_idle_pct = 50;
                recv_idle_pct = 25;
            end
            if (n == N_RANDOM / 2) begin
                // long output hold-off while input keeps coming: fill the pipe
                send_idle_pct = 0;
                hold_req = 1'b1;
            end
            if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            b = rand_mat($urandom_range(9));
            send_beat(b, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (basis_q.size() != 0 || typed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Streamed %0d matrices (%0d degenerate) under mixed back-pressure,",
                 n_beats_out, n_degen);
        $display("including a long output stall and a full drain; %0d mismatches.", n_bad);
        if (n_bad == 0 && basis_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
